// File: design/skvs_pkg.sv
// ----------------------------------------------------------------------------
// Slot key/value store package
// Shared types, codes and byte helpers for the slot key/value store.
// ----------------------------------------------------------------------------
package skvs_pkg;

  localparam int SLOT_TOTAL_DEF = 64;
  localparam int DATA_BYTES_DEF = 16;
  localparam int BUF_BYTES      = 16;
  localparam int BUF_BITS       = 8 * BUF_BYTES;

  localparam logic [2:0] FN_SET       = 3'd0;
  localparam logic [2:0] FN_REMOVE    = 3'd1;
  localparam logic [2:0] FN_GET       = 3'd2;
  localparam logic [2:0] FN_GET_INDEX = 3'd3;
  localparam logic [2:0] FN_CLEAR     = 3'd4;

  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_USE     = 2'd1;
  localparam logic [1:0] ST_REMOVED = 2'd2;

  localparam logic [1:0] RC_OK        = 2'd0;
  localparam logic [1:0] RC_TOO_LARGE = 2'd1;
  localparam logic [1:0] RC_FULL      = 2'd2;
  localparam logic [1:0] RC_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [4:0]  key_size;
    logic [63:0] value_lo;
    logic [63:0] value_hi;
    logic [4:0]  value_size;
    logic [5:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [4:0]  found_length;
    logic [63:0] data_lo;
    logic [63:0] data_hi;
    logic [6:0]  item_count;
  } rsp_t;

  typedef struct packed {
    logic [4:0]          key_len;
    logic [4:0]          value_len;
    logic [BUF_BITS-1:0] bytes;
  } rec_t;

  typedef struct packed {
    logic       st_we;
    logic       rec_we;
    logic [1:0] st_wdata;
  } tbl_wr_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DROP,
    S_WRITE,
    S_DONE
  } state_t;

  function automatic logic [4:0] sat16(input logic [4:0] v);
    return (v > 5'd16) ? 5'd16 : v;
  endfunction

  function automatic logic [BUF_BITS-1:0] byte_mask(input logic [4:0] len);
    logic [BUF_BITS-1:0] m;
    m = '0;
    for (int b = 0; b < BUF_BYTES; b++) begin
      m[8*b +: 8] = (5'(b) < len) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// File: design/slot_key_value_store_core.sv
// ----------------------------------------------------------------------------
// Slot key/value store core
// Table of slots with set, remove, get by key, get key by index and clear.
// ----------------------------------------------------------------------------
// Each set, remove or get walks the whole slot table once through a single
// read port, one slot per cycle; a set or a remove then writes the status of
// the slot it drops or fills. Clear sweeps the status memory; an oversized
// set or an unknown function answers without a walk. After reset the same
// sweep runs before the first request is taken. One request is in work at a
// time; a finished result waits in the output register while the next
// request is taken.
module slot_key_value_store_core #(
  parameter int SLOT_TOTAL = skvs_pkg::SLOT_TOTAL_DEF,
  parameter int DATA_BYTES = skvs_pkg::DATA_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  skvs_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output skvs_pkg::rsp_t rsp
);
  import skvs_pkg::*;

  localparam int IW = $clog2(SLOT_TOTAL);
  localparam int CW = $clog2(SLOT_TOTAL + 1);

  state_t         state, state_next;
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  live_count;
  logic [CW-1:0]  pos;
  logic           clr_resp;
  logic           found, found_next;
  logic           efound, efound_next;
  logic [IW-1:0]  hit_idx;
  logic [IW-1:0]  eidx;
  rec_t           hit_rec;
  req_t           req_q;

  logic [IW-1:0]  rd_addr, wr_addr, evi;
  tbl_wr_t        wr;
  rec_t           rec_wdata, rec_q;
  logic [1:0]     st_q;

  logic [4:0]     klen, vlen, klen_in, vlen_in;
  logic           too_large_in, too_large;
  logic           ev, key_eq, hit_now, emp_now;
  logic           rsp_load;
  rsp_t           rsp_next;

  skvs_table #(.SLOT_TOTAL(SLOT_TOTAL)) u_table (
    .clk       (clk),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr        (wr),
    .rec_wdata (rec_wdata),
    .st_q      (st_q),
    .rec_q     (rec_q)
  );

  assign klen_in      = sat16(req.key_size);
  assign vlen_in      = sat16(req.value_size);
  assign too_large_in = (6'(klen_in) + 6'(vlen_in)) > 6'(DATA_BYTES);
  assign klen         = sat16(req_q.key_size);
  assign vlen         = sat16(req_q.value_size);
  assign too_large    = (6'(klen) + 6'(vlen)) > 6'(DATA_BYTES);

  assign req_stall = (state != S_IDLE);
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  assign ev     = (state == S_SCAN) && (cnt != '0);
  assign evi    = IW'(cnt - CW'(1));
  assign key_eq = (rec_q.key_len == klen) &&
                  (((rec_q.bytes ^ {req_q.key_hi, req_q.key_lo}) & byte_mask(klen)) == '0);

  always_comb begin
    if (req_q.func == FN_GET_INDEX) begin
      hit_now = ev && !found && (st_q == ST_USE) && (int'(pos) == int'(req_q.entry_index));
    end else begin
      hit_now = ev && !found && (st_q == ST_USE) && key_eq;
    end
    emp_now     = ev && !efound && (st_q == ST_EMPTY);
    found_next  = found || hit_now;
    efound_next = efound || emp_now;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (cnt == CW'(SLOT_TOTAL - 1)) begin
          state_next = clr_resp ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          case (req.func)
            FN_CLEAR:                          state_next = S_CLEAR;
            FN_SET:                            state_next = too_large_in ? S_DONE : S_SCAN;
            FN_REMOVE, FN_GET, FN_GET_INDEX:   state_next = S_SCAN;
            default:                           state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (cnt == CW'(SLOT_TOTAL)) begin
          if ((req_q.func == FN_SET || req_q.func == FN_REMOVE) && found_next) begin
            state_next = S_DROP;
          end else if (req_q.func == FN_SET && efound_next) begin
            state_next = S_WRITE;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DROP: begin
        state_next = (req_q.func == FN_SET && efound) ? S_WRITE : S_DONE;
      end
      S_WRITE: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    wr          = '0;
    wr_addr     = '0;
    rd_addr     = (cnt < CW'(SLOT_TOTAL)) ? cnt[IW-1:0] : '0;
    rec_wdata.key_len   = klen;
    rec_wdata.value_len = vlen;
    rec_wdata.bytes     = ({req_q.key_hi, req_q.key_lo} & byte_mask(klen)) |
                          (({req_q.value_hi, req_q.value_lo} & byte_mask(vlen))
                           << {klen, 3'b000});
    case (state)
      S_CLEAR: begin
        wr.st_we    = 1'b1;
        wr.st_wdata = ST_EMPTY;
        wr_addr     = cnt[IW-1:0];
      end
      S_DROP: begin
        wr.st_we    = 1'b1;
        wr.st_wdata = ST_REMOVED;
        wr_addr     = hit_idx;
      end
      S_WRITE: begin
        wr.st_we    = 1'b1;
        wr.rec_we   = 1'b1;
        wr.st_wdata = ST_USE;
        wr_addr     = eidx;
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  always_comb begin
    rsp_next              = '0;
    rsp_next.result_code  = RC_OK;
    rsp_next.item_count   = (int'(live_count) > 127) ? 7'd127 : 7'(live_count);
    case (req_q.func)
      FN_SET: begin
        if (too_large) begin
          rsp_next.result_code = RC_TOO_LARGE;
        end else if (!efound) begin
          rsp_next.result_code = RC_FULL;
        end
      end
      FN_REMOVE: begin
        rsp_next.result_code = found ? RC_OK : RC_NOT_FOUND;
      end
      FN_GET: begin
        rsp_next.result_code = found ? RC_OK : RC_NOT_FOUND;
        if (found) begin
          rsp_next.found_length = hit_rec.value_len;
          {rsp_next.data_hi, rsp_next.data_lo} =
            (hit_rec.bytes >> {hit_rec.key_len, 3'b000}) & byte_mask(hit_rec.value_len);
        end
      end
      FN_GET_INDEX: begin
        rsp_next.result_code = found ? RC_OK : RC_NOT_FOUND;
        if (found) begin
          rsp_next.found_length = hit_rec.key_len;
          {rsp_next.data_hi, rsp_next.data_lo} = hit_rec.bytes & byte_mask(hit_rec.key_len);
        end
      end
      default: begin
        rsp_next.result_code = RC_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      live_count <= '0;
      clr_resp   <= 1'b0;
      found      <= 1'b0;
      efound     <= 1'b0;
      pos        <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + CW'(1);
      if (state == S_IDLE && req_valid) begin
        clr_resp <= (req.func == FN_CLEAR);
        found    <= 1'b0;
        efound   <= 1'b0;
        pos      <= '0;
      end
      if (state == S_SCAN) begin
        found  <= found_next;
        efound <= efound_next;
        if (ev && st_q == ST_USE) begin
          pos <= pos + CW'(1);
        end
      end
      case (state)
        S_CLEAR: live_count <= '0;
        S_DROP:  live_count <= live_count - CW'(1);
        S_WRITE: live_count <= live_count + CW'(1);
        default: live_count <= live_count;
      endcase
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req_q <= req;
    end
    if (hit_now) begin
      hit_idx <= evi;
      hit_rec <= rec_q;
    end
    if (emp_now) begin
      eidx <= evi;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(live_count) <= SLOT_TOTAL)
    else $error("live count beyond slot total");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state != S_IDLE))
    else $error("request transfer left the sequencer idle");

  a_scan_holds_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> $stable(live_count))
    else $error("live count moved during table scan");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside completion");

endmodule

// File: design/skvs_table.sv
// ----------------------------------------------------------------------------
// Slot table storage
// Status and record memories, one write port and one registered read port.
// ----------------------------------------------------------------------------
module skvs_table #(
  parameter int SLOT_TOTAL = skvs_pkg::SLOT_TOTAL_DEF
) (
  input  logic                          clk,
  input  logic [$clog2(SLOT_TOTAL)-1:0] rd_addr,
  input  logic [$clog2(SLOT_TOTAL)-1:0] wr_addr,
  input  skvs_pkg::tbl_wr_t             wr,
  input  skvs_pkg::rec_t                rec_wdata,
  output logic [1:0]                    st_q,
  output skvs_pkg::rec_t                rec_q
);
  import skvs_pkg::*;

  logic [1:0] st_mem  [SLOT_TOTAL];
  rec_t       rec_mem [SLOT_TOTAL];

  always_ff @(posedge clk) begin
    if (wr.st_we) begin
      st_mem[wr_addr] <= wr.st_wdata;
    end
    st_q <= st_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.rec_we) begin
      rec_mem[wr_addr] <= rec_wdata;
    end
    rec_q <= rec_mem[rd_addr];
  end

endmodule

// File: tb/slot_key_value_store_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot key/value store core testbench
// Drives directed and random requests through the valid/stall request channel,
// predicts every response with a behavioural slot table and compares each
// response field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module slot_key_value_store_core_tb;
  import skvs_pkg::*;

  localparam int SLOTS       = 64;
  localparam int RANDOM_REQS = 1280;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  logic [1:0]   tbl_status [SLOTS];
  logic [4:0]   tbl_klen   [SLOTS];
  logic [4:0]   tbl_vlen   [SLOTS];
  logic [127:0] tbl_bytes  [SLOTS];
  int unsigned  live_items;

  rsp_t pending_rsp[$];
  int   fail_count = 0;
  bit   quiet = 1'b0;

  logic [63:0] key_pool_lo [8];
  logic [63:0] key_pool_hi [8];
  logic [4:0]  key_pool_len [8];

  slot_key_value_store_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [127:0] masked(input logic [127:0] b, input logic [4:0] n);
    logic [127:0] m;
    m = '0;
    for (int i = 0; i < 16; i++) if (i < n) m[8*i +: 8] = 8'hFF;
    return b & m;
  endfunction

  function automatic int lookup_key(input logic [127:0] k, input logic [4:0] n);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_status[i] == ST_USE && tbl_klen[i] == n &&
          masked(tbl_bytes[i], n) == masked(k, n)) return i;
    return -1;
  endfunction

  function automatic rsp_t apply_request(input req_t r);
    rsp_t o;
    logic [4:0] kl, vl;
    logic [127:0] k, v;
    int s, p;
    o = '0;
    kl = sat16(r.key_size);
    vl = sat16(r.value_size);
    k = {r.key_hi, r.key_lo};
    v = {r.value_hi, r.value_lo};
    case (r.func)
      FN_SET: begin
        if (kl + vl > 16) o.result_code = RC_TOO_LARGE;
        else begin
          s = lookup_key(k, kl);
          if (s >= 0) begin
            tbl_status[s] = ST_REMOVED;
            live_items--;
          end
          s = -1;
          for (int i = 0; i < SLOTS && s < 0; i++) if (tbl_status[i] == ST_EMPTY) s = i;
          if (s < 0) o.result_code = RC_FULL;
          else begin
            tbl_bytes[s] = masked(k, kl) | (masked(v, vl) << (8 * kl));
            tbl_status[s] = ST_USE;
            tbl_klen[s] = kl;
            tbl_vlen[s] = vl;
            live_items++;
          end
        end
      end
      FN_REMOVE: begin
        s = lookup_key(k, kl);
        if (s < 0) o.result_code = RC_NOT_FOUND;
        else begin
          tbl_status[s] = ST_REMOVED;
          live_items--;
        end
      end
      FN_GET: begin
        s = lookup_key(k, kl);
        if (s < 0) o.result_code = RC_NOT_FOUND;
        else begin
          o.found_length = tbl_vlen[s];
          {o.data_hi, o.data_lo} = masked(tbl_bytes[s] >> (8 * tbl_klen[s]), tbl_vlen[s]);
        end
      end
      FN_GET_INDEX: begin
        s = -1;
        p = 0;
        for (int i = 0; i < SLOTS && s < 0; i++)
          if (tbl_status[i] == ST_USE) begin
            if (p == r.entry_index) s = i;
            p++;
          end
        if (s < 0) o.result_code = RC_NOT_FOUND;
        else begin
          o.found_length = tbl_klen[s];
          {o.data_hi, o.data_lo} = masked(tbl_bytes[s], tbl_klen[s]);
        end
      end
      FN_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) tbl_status[i] = ST_EMPTY;
        live_items = 0;
      end
      default: ;
    endcase
    o.item_count = (live_items > 127) ? 7'd127 : 7'(live_items);
    return o;
  endfunction

  task automatic send_request(input req_t r, input bit has_fixed, input rsp_t fixed);
    rsp_t p;
    if (!quiet) begin
      while ($urandom_range(0, 5) == 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    p = apply_request(r);
    if (has_fixed && p != fixed) begin
      $error("expected response for row disagrees with predictor: %h vs %h", fixed, p);
      fail_count++;
    end
    pending_rsp.push_back(has_fixed ? fixed : p);
  endtask

  function automatic req_t make_req(input logic [2:0] f, input logic [127:0] k,
                                    input logic [4:0] kl, input logic [127:0] v,
                                    input logic [4:0] vl, input logic [5:0] ix);
    req_t r;
    r.func = f;
    {r.key_hi, r.key_lo} = k;
    r.key_size = kl;
    {r.value_hi, r.value_lo} = v;
    r.value_size = vl;
    r.entry_index = ix;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(input logic [1:0] c, input logic [6:0] n);
    rsp_t o;
    o = '0;
    o.result_code = c;
    o.item_count = n;
    return o;
  endfunction

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic req_t random_req();
    req_t r;
    int sel, pk;
    logic [127:0] k;
    logic [4:0] kl;
    sel = $urandom_range(0, 99);
    pk = $urandom_range(0, 7);
    k = {key_pool_hi[pk], key_pool_lo[pk]};
    kl = key_pool_len[pk];
    if ($urandom_range(0, 9) == 0) begin
      k = rand128();
      kl = 5'($urandom_range(0, 31));
    end else begin
      k = masked(k, kl) | (rand128() & ~masked('1, kl));
    end
    if (sel < 45)
      r = make_req(FN_SET, k, kl, rand128(), 5'($urandom_range(0, 16 - (kl > 16 ? 16 : kl))),
                   6'($urandom));
    else if (sel < 50)
      r = make_req(FN_SET, k, kl, rand128(), 5'($urandom_range(0, 31)), 6'($urandom));
    else if (sel < 62) r = make_req(FN_REMOVE, k, kl, rand128(), 5'($urandom), 6'($urandom));
    else if (sel < 80) r = make_req(FN_GET, k, kl, rand128(), 5'($urandom), 6'($urandom));
    else if (sel < 95)
      r = make_req(FN_GET_INDEX, k, kl, rand128(), 5'($urandom),
                   6'($urandom_range(0, live_items + 2)));
    else if (sel < 97) r = make_req(FN_CLEAR, k, kl, rand128(), 5'($urandom), 6'($urandom));
    else r = make_req(3'($urandom_range(5, 7)), k, kl, rand128(), 5'($urandom), 6'($urandom));
    return r;
  endfunction

  // response checker and stall generator
  always @(posedge clk) begin
    rsp_t e;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          $error("response with nothing expected: %h", rsp);
          fail_count++;
        end else begin
          e = pending_rsp.pop_front();
          if (rsp.result_code !== e.result_code) begin
            $error("result_code expected %0d actual %0d", e.result_code, rsp.result_code);
            fail_count++;
          end
          if (rsp.found_length !== e.found_length) begin
            $error("found_length expected %0d actual %0d", e.found_length, rsp.found_length);
            fail_count++;
          end
          if (rsp.data_lo !== e.data_lo) begin
            $error("data_lo expected %h actual %h", e.data_lo, rsp.data_lo);
            fail_count++;
          end
          if (rsp.data_hi !== e.data_hi) begin
            $error("data_hi expected %h actual %h", e.data_hi, rsp.data_hi);
            fail_count++;
          end
          if (rsp.item_count !== e.item_count) begin
            $error("item_count expected %0d actual %0d", e.item_count, rsp.item_count);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 5);
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
    end
  end

  initial begin
    #20_000_000;
    $display("** slot_key_value_store_core: FAILED **");
    $finish;
  end

  initial begin
    req_t  dir_req [$];
    bit    dir_fix [$];
    rsp_t  dir_rsp [$];
    logic [127:0] all1;
    all1 = '1;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_status[i] = ST_EMPTY;
      tbl_klen[i] = '0;
      tbl_vlen[i] = '0;
      tbl_bytes[i] = '0;
    end
    live_items = 0;
    for (int i = 0; i < 8; i++) begin
      key_pool_lo[i] = {$urandom, $urandom};
      key_pool_hi[i] = {$urandom, $urandom};
      key_pool_len[i] = 5'($urandom_range(0, 16));
    end
    key_pool_len[0] = 5'd16;
    key_pool_len[1] = 5'd0;

    // directed table
    dir_req.push_back(make_req(FN_GET, all1, 5'd16, '0, 5'd0, 6'd0));
    dir_fix.push_back(1); dir_rsp.push_back(mk_rsp(RC_NOT_FOUND, 7'd0));
    dir_req.push_back(make_req(FN_GET_INDEX, '0, 5'd0, '0, 5'd0, 6'd63));
    dir_fix.push_back(1); dir_rsp.push_back(mk_rsp(RC_NOT_FOUND, 7'd0));
    dir_req.push_back(make_req(FN_SET, all1, 5'd16, all1, 5'd1, 6'd0));
    dir_fix.push_back(1); dir_rsp.push_back(mk_rsp(RC_TOO_LARGE, 7'd0));
    dir_req.push_back(make_req(FN_SET, all1, 5'd31, all1, 5'd31, 6'd0));
    dir_fix.push_back(1); dir_rsp.push_back(mk_rsp(RC_TOO_LARGE, 7'd0));
    dir_req.push_back(make_req(FN_SET, all1, 5'd31, all1, 5'd0, 6'd0));
    dir_fix.push_back(1); dir_rsp.push_back(mk_rsp(RC_OK, 7'd1));
    dir_req.push_back(make_req(FN_SET, '0, 5'd0, all1, 5'd16, 6'd0));
    dir_fix.push_back(1); dir_rsp.push_back(mk_rsp(RC_OK, 7'd2));
    dir_req.push_back(make_req(FN_GET, all1, 5'd0, '0, 5'd0, 6'd0));
    dir_fix.push_back(0); dir_rsp.push_back('0);
    dir_req.push_back(make_req(FN_GET_INDEX, '0, 5'd0, '0, 5'd0, 6'd0));
    dir_fix.push_back(0); dir_rsp.push_back('0);
    dir_req.push_back(make_req(FN_SET, 128'h0123456789abcdef_fedcba9876543210, 5'd4,
                               all1, 5'd12, 6'd0));
    dir_fix.push_back(1); dir_rsp.push_back(mk_rsp(RC_OK, 7'd3));
    dir_req.push_back(make_req(FN_SET, 128'h55_76543210, 5'd4, 128'h1234, 5'd2, 6'd0));
    dir_fix.push_back(1); dir_rsp.push_back(mk_rsp(RC_OK, 7'd3));
    dir_req.push_back(make_req(FN_GET, 128'h76543210, 5'd4, '0, 5'd0, 6'd0));
    dir_fix.push_back(0); dir_rsp.push_back('0);
    dir_req.push_back(make_req(FN_GET_INDEX, '0, 5'd0, '0, 5'd0, 6'd2));
    dir_fix.push_back(0); dir_rsp.push_back('0);
    dir_req.push_back(make_req(FN_REMOVE, '0, 5'd0, '0, 5'd0, 6'd0));
    dir_fix.push_back(1); dir_rsp.push_back(mk_rsp(RC_OK, 7'd2));
    dir_req.push_back(make_req(FN_REMOVE, '0, 5'd0, '0, 5'd0, 6'd0));
    dir_fix.push_back(1); dir_rsp.push_back(mk_rsp(RC_NOT_FOUND, 7'd2));
    dir_req.push_back(make_req(3'd5, all1, 5'd16, all1, 5'd16, 6'd63));
    dir_fix.push_back(1); dir_rsp.push_back(mk_rsp(RC_OK, 7'd2));
    dir_req.push_back(make_req(3'd7, '0, 5'd0, '0, 5'd0, 6'd0));
    dir_fix.push_back(1); dir_rsp.push_back(mk_rsp(RC_OK, 7'd2));
    dir_req.push_back(make_req(FN_CLEAR, '0, 5'd0, '0, 5'd0, 6'd0));
    dir_fix.push_back(1); dir_rsp.push_back(mk_rsp(RC_OK, 7'd0));
    dir_req.push_back(make_req(FN_GET_INDEX, '0, 5'd0, '0, 5'd0, 6'd0));
    dir_fix.push_back(1); dir_rsp.push_back(mk_rsp(RC_NOT_FOUND, 7'd0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < dir_req.size(); i++) send_request(dir_req[i], dir_fix[i], dir_rsp[i]);

    // fill the table to reach the full error, then hold until drained
    for (int i = 0; i < SLOTS + 2; i++)
      send_request(make_req(FN_SET, 128'(i), 5'd2, rand128(), 5'd8, 6'd0), 0, '0);
    send_request(make_req(FN_GET_INDEX, '0, 5'd0, '0, 5'd0, 6'd63), 0, '0);
    send_request(make_req(FN_SET, 128'd5, 5'd2, '0, 5'd0, 6'd0), 0, '0);
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    send_request(make_req(FN_CLEAR, '0, 5'd0, '0, 5'd0, 6'd0), 0, '0);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i == RANDOM_REQS - 150) quiet = 1'b1;
      send_request(random_req(), 0, '0);
    end
    req_valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SLOTS + 20) @(posedge clk);
    if (fail_count == 0 && pending_rsp.size() == 0) begin
      $display("** slot_key_value_store_core: PASSED **");
    end else begin
      $display("** slot_key_value_store_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
design/skvs_pkg.sv
design/skvs_table.sv
design/slot_key_value_store_core.sv
tb/slot_key_value_store_core_tb.sv
